// ===== design/round_robin_route_table_assert.svh =====
// ---------------------------------------------------------------------------
// round robin route table assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_ROUTE_TABLE_ASSERT_SVH
`define ROUND_ROBIN_ROUTE_TABLE_ASSERT_SVH

// condition holds at every edge
`define RRRT_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RRRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define RRRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrrt_pkg.sv =====
// ---------------------------------------------------------------------------
// rrrt_pkg
// shared types and codes of the round robin route table
// ---------------------------------------------------------------------------
package rrrt_pkg;

  // request kinds
  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_LOOKUP   = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    STAT_NEW_SLOT    = 3'd0,
    STAT_ADDED       = 3'd1,
    STAT_DUPLICATE   = 3'd2,
    STAT_ROUTES_FULL = 3'd3,
    STAT_TABLE_FULL  = 3'd4,
    STAT_HIT         = 3'd5,
    STAT_MISS        = 3'd6
  } rrrt_status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_FOUND,
    ST_ROUTE,
    ST_PICK,
    ST_NEW,
    ST_OUT
  } rrrt_state_t;

endpackage

// ===== design/round_robin_route_table.sv =====
// ---------------------------------------------------------------------------
// round_robin_route_table
// slot table keyed by 64-bit address, each slot with a short route list
// and a round-robin pick pointer, held in two synchronous memories
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  in      | input     | in_valid/stall   | req_type, address, route_id
//  out     | output    | out_valid/stall  | status, selected_route
//
//  one item at a time; the slot memory is scanned one entry per cycle, up to and
//  including the match (all used slots on a miss or new slot), and a route
//  registered to a known slot then scans its listed routes, one per cycle
//  reset clears the control state and used-slot count, not the memories, no clearing pass is needed
//  a new item is taken while the previous result still waits on out_stall
// ---------------------------------------------------------------------------
`include "round_robin_route_table_assert.svh"

module round_robin_route_table
  import rrrt_pkg::*;
#(
  parameter int SLOT_COUNT      = 16,
  parameter int ROUTES_PER_SLOT = 4,
  parameter int ROUTE_ID_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request transfer
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [63:0]              in_address,
  input  logic [ROUTE_ID_BITS-1:0] in_route_id,
  // result transfer
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic [ROUTE_ID_BITS-1:0] out_selected_route
);

  // widths derived from the table shape
  localparam int SW   = $clog2(SLOT_COUNT);                        // slot index
  localparam int SUW  = $clog2(SLOT_COUNT + 1);                    // used-slot count
  localparam int CW   = $clog2(ROUTES_PER_SLOT + 1);               // route count
  localparam int PW   = (ROUTES_PER_SLOT > 1) ? $clog2(ROUTES_PER_SLOT) : 1;
  localparam int RD   = SLOT_COUNT * ROUTES_PER_SLOT;              // route entries
  localparam int RIW  = $clog2(RD);                                // route index
  localparam int CNTW = (SUW > CW) ? SUW : CW;                     // scan counter
  localparam int MW   = 64 + CW + PW;                              // slot record

  // slot record memory {address, route count, pick pointer}
  logic [MW-1:0]            meta_mem [SLOT_COUNT];
  logic [MW-1:0]            meta_q;
  logic [SW-1:0]            meta_raddr;
  logic                     meta_we;
  logic [SW-1:0]            meta_waddr;
  logic [MW-1:0]            meta_wdata;

  // route list memory, ROUTES_PER_SLOT entries per slot
  logic [ROUTE_ID_BITS-1:0] route_mem [RD];
  logic [ROUTE_ID_BITS-1:0] route_q;
  logic [RIW-1:0]           route_raddr;
  logic                     route_we;
  logic [RIW-1:0]           route_waddr;

  // control state
  rrrt_state_t              state_r, state_nxt;
  logic [SUW-1:0]           slots_used_r, slots_used_nxt;
  logic [CNTW-1:0]          scan_cnt_r, scan_cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // working registers of the current item
  logic                     req_r, req_nxt;
  logic [63:0]              addr_r, addr_nxt;
  logic [ROUTE_ID_BITS-1:0] rid_r, rid_nxt;
  logic [SW-1:0]            pend_idx_r, pend_idx_nxt;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [PW-1:0]            pick_r, pick_nxt;
  rrrt_status_t             status_r, status_nxt;
  logic [ROUTE_ID_BITS-1:0] sel_r, sel_nxt;
  rrrt_status_t             out_status_r, out_status_nxt;
  logic [ROUTE_ID_BITS-1:0] out_route_r, out_route_nxt;

  // decoded read data and scan conditions
  logic [63:0]              meta_q_addr;
  logic [CW-1:0]            meta_q_cnt;
  logic [PW-1:0]            meta_q_pick;
  logic                     slot_hit;
  logic                     slot_more;
  logic                     route_dup;
  logic                     route_more;
  logic                     table_full;
  logic                     routes_full;
  logic                     out_free;
  logic                     in_xfer;
  logic [RIW-1:0]           slot_base;
  logic [CW-1:0]            pick_inc;
  logic [PW-1:0]            pick_wrap;

  assign meta_q_addr = meta_q[MW-1:CW+PW];
  assign meta_q_cnt  = meta_q[CW+PW-1:PW];
  assign meta_q_pick = meta_q[PW-1:0];

  // a compare is valid in the cycle after its read was issued
  assign slot_hit    = pend_r && (meta_q_addr == addr_r);
  assign slot_more   = scan_cnt_r < CNTW'(slots_used_r);
  assign route_dup   = pend_r && (route_q == rid_r);
  assign route_more  = scan_cnt_r < CNTW'(cnt_r);
  assign table_full  = slots_used_r == SUW'(SLOT_COUNT);
  assign routes_full = cnt_r == CW'(ROUTES_PER_SLOT);

  // first route entry of the working slot
  assign slot_base   = RIW'(RIW'(slot_r) * RIW'(ROUTES_PER_SLOT));

  // round-robin advance, back to zero past the last listed route
  assign pick_inc    = CW'(pick_r) + CW'(1);
  assign pick_wrap   = (pick_inc >= cnt_r) ? '0 : PW'(pick_inc);

  // result register is free unless a result sits stalled in it
  assign out_free    = !(out_valid_r && out_stall);
  assign in_stall    = state_r != ST_IDLE;
  assign in_xfer     = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        if (slot_hit) begin
          state_nxt = ST_FOUND;
        end else if (slot_more) begin
          state_nxt = ST_SLOT;
        end else if (req_r == REQ_LOOKUP || table_full) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_NEW;
        end
      end
      ST_FOUND: begin
        state_nxt = (req_r == REQ_LOOKUP) ? ST_PICK : ST_ROUTE;
      end
      ST_ROUTE: begin
        if (!route_dup && route_more) state_nxt = ST_ROUTE;
        else state_nxt = ST_OUT;
      end
      ST_PICK: state_nxt = ST_OUT;
      ST_NEW:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    slots_used_nxt = slots_used_r;
    scan_cnt_nxt   = scan_cnt_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    rid_nxt        = rid_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    pick_nxt       = pick_r;
    status_nxt     = status_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_route_nxt  = out_route_r;
    meta_raddr     = scan_cnt_r[SW-1:0];
    meta_we        = 1'b0;
    meta_waddr     = slot_r;
    meta_wdata     = {addr_r, cnt_r, pick_r};
    route_raddr    = slot_base + RIW'(scan_cnt_r);
    route_we       = 1'b0;
    route_waddr    = slot_base + RIW'(cnt_r);

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          req_nxt      = in_req_type;
          addr_nxt     = in_address;
          rid_nxt      = in_route_id;
          scan_cnt_nxt = '0;
        end
      end
      ST_SLOT: begin
        if (slot_hit) begin
          slot_nxt = pend_idx_r;
          cnt_nxt  = meta_q_cnt;
          pick_nxt = meta_q_pick;
        end else if (slot_more) begin
          // issue the next slot read, compare it next cycle
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_cnt_r[SW-1:0];
          scan_cnt_nxt = scan_cnt_r + CNTW'(1);
        end else begin
          sel_nxt  = '0;
          slot_nxt = slots_used_r[SW-1:0];
          if (req_r == REQ_LOOKUP) status_nxt = STAT_MISS;
          else if (table_full) status_nxt = STAT_TABLE_FULL;
          else status_nxt = STAT_NEW_SLOT;
        end
      end
      ST_FOUND: begin
        // lookup reads the route under the pointer, register scans the list
        route_raddr  = slot_base + RIW'(pick_r);
        scan_cnt_nxt = '0;
      end
      ST_ROUTE: begin
        if (route_dup) begin
          status_nxt = STAT_DUPLICATE;
          sel_nxt    = '0;
        end else if (route_more) begin
          pend_nxt     = 1'b1;
          scan_cnt_nxt = scan_cnt_r + CNTW'(1);
        end else begin
          sel_nxt = '0;
          if (routes_full) begin
            status_nxt = STAT_ROUTES_FULL;
          end else begin
            status_nxt = STAT_ADDED;
            route_we   = 1'b1;
            meta_we    = 1'b1;
            meta_wdata = {addr_r, cnt_r + CW'(1), pick_r};
          end
        end
      end
      ST_PICK: begin
        status_nxt = STAT_HIT;
        sel_nxt    = route_q;
        meta_we    = 1'b1;
        meta_wdata = {addr_r, cnt_r, pick_wrap};
      end
      ST_NEW: begin
        // open the slot with one route and the pointer at zero
        meta_we        = 1'b1;
        meta_wdata     = {addr_r, CW'(1), PW'(0)};
        route_we       = 1'b1;
        route_waddr    = slot_base;
        slots_used_nxt = slots_used_r + SUW'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_route_nxt  = sel_r;
        end
      end
      default: begin
      end
    endcase
  end

  // slot record memory, registered read
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_q <= meta_mem[meta_raddr];
  end

  // route list memory, registered read
  always_ff @(posedge clk) begin
    if (route_we) route_mem[route_waddr] <= rid_r;
    route_q <= route_mem[route_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slots_used_r <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_cnt_r   <= scan_cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    rid_r        <= rid_nxt;
    slot_r       <= slot_nxt;
    cnt_r        <= cnt_nxt;
    pick_r       <= pick_nxt;
    status_r     <= status_nxt;
    sel_r        <= sel_nxt;
    out_status_r <= out_status_nxt;
    out_route_r  <= out_route_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_selected_route = out_route_r;

  // checks
  `RRRT_ASSERT_NOW(a_used_bound, slots_used_r <= SUW'(SLOT_COUNT), "used slots overrun")
  `RRRT_ASSERT_IMPL(a_pick_in_range, state_r == ST_PICK, pick_r < cnt_r, "pick out of range")
  `RRRT_ASSERT_NEXT(a_used_only_new, state_r != ST_NEW, $stable(slots_used_r), "used moved")
  `RRRT_ASSERT_NEXT(a_accept_scan, in_valid && !in_stall, state_r == ST_SLOT, "no scan")

endmodule
